// File: rtl/core/tts_pkg.sv
// Shared types, character codes and class functions for the text token splitter.
// No dependencies; used by tts_scan, tts_fifo and text_token_splitter.
package tts_pkg;

	localparam int FIELD_W    = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_BSLASH     = 8'h5C;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_E_UP       = 8'h45;
	localparam logic [7:0] CH_E_LO       = 8'h65;
	localparam logic [7:0] CH_UP_A       = 8'h41;
	localparam logic [7:0] CH_UP_Z       = 8'h5A;
	localparam logic [7:0] CH_LO_A       = 8'h61;
	localparam logic [7:0] CH_LO_Z       = 8'h7A;
	localparam logic [7:0] CH_DIG_0      = 8'h30;
	localparam logic [7:0] CH_DIG_9      = 8'h39;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_IDENT = 3'd1,
		MODE_STR   = 3'd2,
		MODE_ESC   = 3'd3,
		MODE_NUM   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_IDENT = 2'd0,
		KIND_STR   = 2'd1,
		KIND_NUM   = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [FIELD_W-1:0]  offset;
		logic [FIELD_W-1:0]  length;
		logic                unterm;
		logic                last;
	} desc_t;

	// up to two descriptors per byte, first one in d0
	typedef struct packed {
		logic  v0;
		logic  v1;
		desc_t d0;
		desc_t d1;
	} scan_res_t;

	function automatic logic is_letter(input logic [7:0] ch);
		return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= CH_DIG_0 && ch <= CH_DIG_9;
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
	endfunction

	function automatic logic ident_more(input logic [7:0] ch);
		return is_letter(ch) || is_digit(ch) || ch == CH_UNDERSCORE;
	endfunction

	function automatic logic num_start(input logic [7:0] ch);
		return is_digit(ch) || ch == CH_PLUS || ch == CH_MINUS || ch == CH_DOT;
	endfunction

	function automatic logic num_more(input logic [7:0] ch);
		return num_start(ch) || ch == CH_E_UP || ch == CH_E_LO;
	endfunction

endpackage

// File: rtl/core/text_token_splitter.sv
// An accepted byte sits in the input stage, and its descriptors enter the output queue
// when it advances; m_tvalid is then driven from the registered queue count.
// Throughput: one byte per cycle while each byte yields at most one descriptor and m_tready
// stays high; the single output port drains one descriptor a cycle, so the second descriptor
// of a byte that closes one token and yields another waits in the four-entry queue.
// Reset (arst_n low): scanner between tokens at offset zero, input stage and queue empty.
module text_token_splitter #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] token_offset, [63:32] token_length
	output logic [2:0]  m_tuser,   // [1:0] token_kind, [2] unterminated
	output logic        m_tlast    // final_of_run
);

	// Input stage: one byte plus its end-of-buffer mark.
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	logic               adv;
	logic               room;
	tts_pkg::scan_res_t res;
	tts_pkg::desc_t     head;

	// The byte leaves the input stage once the queue can take both possible
	// descriptors; the stage refills in the same cycle, so no bubble.
	assign adv      = vld_s1 && room;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eob_s1  <= s_tlast;
		end
	end

	// Character-class state machine; state commits only when the byte advances.
	tts_scan #(
		.OFS_W (OFFSET_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (byte_s1),
		.eob    (eob_s1),
		.adv    (adv),
		.res    (res)
	);

	// Result queue parts the scanner from the output handshake.
	tts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (adv && res.v0),
		.push1     (adv && res.v1),
		.d0        (res.d0),
		.d1        (res.d1),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_desc  (head)
	);

	assign m_tdata = {head.length, head.offset};
	assign m_tuser = {head.unterm, head.kind};
	assign m_tlast = head.last;

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(byte_s1) && $stable(eob_s1))
		else $error("input stage lost a byte while stalled");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !room |-> !s_tready)
		else $error("input taken while the stage could not drain");

	a_unterm_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == tts_pkg::KIND_STR)
		else $error("unterminated flag on a non-string token");

endmodule

// File: rtl/core/tts_scan.sv
// Per-byte scanner: mode, token start and position registers plus descriptor logic.
// Depends on tts_pkg.
module tts_scan #(
	parameter int OFS_W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          ch,
	input  logic                eob,
	input  logic                adv,
	output tts_pkg::scan_res_t  res
);

	localparam logic [OFS_W-1:0] ONE = OFS_W'(1);

	tts_pkg::mode_t   mode_q, mode_mid, mode_nxt;
	logic [OFS_W-1:0] begin_q, begin_mid, begin_nxt;
	logic [OFS_W-1:0] pos_q, pos_nxt;
	logic             consumed, end_tok, other_tok, tail_tok;
	logic [OFS_W-1:0] len_end, len_tail;
	tts_pkg::desc_t   dsc_end, dsc_other, dsc_tail;
	logic [1:0]       n_res;

	// next state
	always_comb begin
		consumed  = 1'b0;
		end_tok   = 1'b0;
		other_tok = 1'b0;
		mode_mid  = mode_q;
		begin_mid = begin_q;
		unique case (mode_q)
			tts_pkg::MODE_IDENT: begin
				if (tts_pkg::ident_more(ch)) begin
					consumed = 1'b1;
				end else begin
					end_tok  = 1'b1;
					mode_mid = tts_pkg::MODE_IDLE;
				end
			end
			tts_pkg::MODE_NUM: begin
				if (tts_pkg::num_more(ch)) begin
					consumed = 1'b1;
				end else begin
					end_tok  = 1'b1;
					mode_mid = tts_pkg::MODE_IDLE;
				end
			end
			tts_pkg::MODE_STR: begin
				consumed = 1'b1;
				if (ch == tts_pkg::CH_BSLASH) begin
					mode_mid = tts_pkg::MODE_ESC;
				end else if (ch == tts_pkg::CH_QUOTE) begin
					end_tok  = 1'b1;
					mode_mid = tts_pkg::MODE_IDLE;
				end
			end
			tts_pkg::MODE_ESC: begin
				consumed = 1'b1;
				mode_mid = tts_pkg::MODE_STR;
			end
			default: begin
				mode_mid = tts_pkg::MODE_IDLE;
			end
		endcase
		if (!consumed) begin
			if (tts_pkg::is_space(ch)) begin
				// separator
			end else if (tts_pkg::is_letter(ch) || ch == tts_pkg::CH_UNDERSCORE) begin
				mode_mid  = tts_pkg::MODE_IDENT;
				begin_mid = pos_q;
			end else if (ch == tts_pkg::CH_QUOTE) begin
				mode_mid  = tts_pkg::MODE_STR;
				begin_mid = pos_q;
			end else if (tts_pkg::num_start(ch)) begin
				mode_mid  = tts_pkg::MODE_NUM;
				begin_mid = pos_q;
			end else begin
				other_tok = 1'b1;
			end
		end
		mode_nxt  = eob ? tts_pkg::MODE_IDLE : mode_mid;
		begin_nxt = eob ? '0 : begin_mid;
		pos_nxt   = eob ? '0 : pos_q + ONE;
	end

	// descriptors
	always_comb begin
		tail_tok = eob && (mode_mid == tts_pkg::MODE_IDENT || mode_mid == tts_pkg::MODE_NUM ||
			mode_mid == tts_pkg::MODE_STR || mode_mid == tts_pkg::MODE_ESC);
		len_end  = pos_q - begin_q + ((mode_q == tts_pkg::MODE_STR) ? ONE : '0);
		len_tail = pos_q - begin_mid + ONE;

		dsc_end.kind   = (mode_q == tts_pkg::MODE_IDENT) ? tts_pkg::KIND_IDENT :
			(mode_q == tts_pkg::MODE_NUM) ? tts_pkg::KIND_NUM : tts_pkg::KIND_STR;
		dsc_end.offset = tts_pkg::FIELD_W'(begin_q);
		dsc_end.length = tts_pkg::FIELD_W'(len_end);
		dsc_end.unterm = 1'b0;
		dsc_end.last   = 1'b0;

		dsc_other.kind   = tts_pkg::KIND_OTHER;
		dsc_other.offset = tts_pkg::FIELD_W'(pos_q);
		dsc_other.length = tts_pkg::FIELD_W'(1);
		dsc_other.unterm = 1'b0;
		dsc_other.last   = 1'b0;

		dsc_tail.kind   = (mode_mid == tts_pkg::MODE_IDENT) ? tts_pkg::KIND_IDENT :
			(mode_mid == tts_pkg::MODE_NUM) ? tts_pkg::KIND_NUM : tts_pkg::KIND_STR;
		dsc_tail.offset = tts_pkg::FIELD_W'(begin_mid);
		dsc_tail.length = tts_pkg::FIELD_W'(len_tail);
		dsc_tail.unterm = mode_mid == tts_pkg::MODE_STR || mode_mid == tts_pkg::MODE_ESC;
		dsc_tail.last   = 1'b0;

		// a one-byte token leaves the scanner idle, so it never pairs with a tail
		n_res = 2'(end_tok) + 2'(other_tok) + 2'(tail_tok);
		res.v0 = n_res != 2'd0;
		res.v1 = n_res == 2'd2;
		res.d0 = end_tok ? dsc_end : (other_tok ? dsc_other : dsc_tail);
		res.d1 = other_tok ? dsc_other : dsc_tail;
		res.d0.last = n_res == 2'd1;
		res.d1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tts_pkg::MODE_IDLE;
			begin_q <= '0;
			pos_q   <= '0;
		end else if (adv) begin
			mode_q  <= mode_nxt;
			begin_q <= begin_nxt;
			pos_q   <= pos_nxt;
		end
	end

	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eob |=> mode_q == tts_pkg::MODE_IDLE && pos_q == '0 && begin_q == '0)
		else $error("scanner did not restart after end of buffer");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eob |=> pos_q == $past(pos_q) + ONE)
		else $error("byte position did not advance by one");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		res.v1 |-> res.v0 && !res.d0.last)
		else $error("second descriptor without an open first one");

endmodule

// File: rtl/core/tts_fifo.sv
// Four-entry descriptor queue: up to two writes and one read per cycle.
// Depends on tts_pkg.
module tts_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push0,
	input  logic            push1,
	input  tts_pkg::desc_t  d0,
	input  tts_pkg::desc_t  d1,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output tts_pkg::desc_t  out_desc
);

	tts_pkg::desc_t                  mem_q [tts_pkg::FIFO_DEPTH];
	logic [tts_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [tts_pkg::FIFO_CNT_W-1:0]  count_q;
	logic                            pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_desc  = mem_q[rd_ptr_q];
	// room for two, judged before this cycle's read
	assign room      = count_q <= tts_pkg::FIFO_CNT_W'(tts_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= d0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + tts_pkg::FIFO_PTR_W'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tts_pkg::FIFO_PTR_W'(push0) + tts_pkg::FIFO_PTR_W'(push1);
			rd_ptr_q <= rd_ptr_q + tts_pkg::FIFO_PTR_W'(pop);
			count_q  <= count_q + tts_pkg::FIFO_CNT_W'(push0) + tts_pkg::FIFO_CNT_W'(push1)
				- tts_pkg::FIFO_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room)
		else $error("descriptor queue written without room");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second slot written without the first");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tts_pkg::FIFO_CNT_W'(tts_pkg::FIFO_DEPTH))
		else $error("descriptor queue count out of range");

endmodule

// File: bench/text_token_splitter_tb.sv
// Self-checking bench for text_token_splitter: byte stream in, token descriptors out.
// Depends on tts_pkg (mode, kind, descriptor types and character codes) and the RTL top.
module text_token_splitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// No transaction on either side for this many cycles ends the run.
	localparam int STALL_LIMIT = 1000;
	// Cycles allowed after the last descriptor before the verdict.
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
	logic        s_tlast = 1'b0;    // end_of_buffer
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // [31:0] token_offset, [63:32] token_length
	logic [2:0]  m_tuser;           // [1:0] token_kind, [2] unterminated
	logic        m_tlast;           // final_of_run

	// Random idling on the send side and the receive side.
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	// Shadow tokenizer state.
	tts_pkg::mode_t scan_st = tts_pkg::MODE_IDLE;
	logic [31:0]    tok_start = '0;
	logic [31:0]    cur_pos = '0;

	// Descriptors predicted but not yet seen on the output, oldest first.
	tts_pkg::desc_t pending_tokens[$];
	tts_pkg::desc_t want_d;

	logic [7:0]  text_buf[$];

	int mismatches = 0;
	int bytes_taken = 0;
	int buffers_taken = 0;
	int tokens_seen = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	text_token_splitter #(
		.OFFSET_BITS(32)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// ---------------------------------------------------------------- character classes

	function automatic bit letter_ch(input logic [7:0] c);
		return (c >= tts_pkg::CH_UP_A && c <= tts_pkg::CH_UP_Z) ||
			(c >= tts_pkg::CH_LO_A && c <= tts_pkg::CH_LO_Z);
	endfunction

	function automatic bit digit_ch(input logic [7:0] c);
		return c >= tts_pkg::CH_DIG_0 && c <= tts_pkg::CH_DIG_9;
	endfunction

	function automatic bit blank_ch(input logic [7:0] c);
		return c == tts_pkg::CH_SPACE || c == tts_pkg::CH_TAB || c == tts_pkg::CH_CR ||
			c == tts_pkg::CH_LF;
	endfunction

	// may continue an identifier
	function automatic bit word_ch(input logic [7:0] c);
		return letter_ch(c) || digit_ch(c) || c == tts_pkg::CH_UNDERSCORE;
	endfunction

	// may open a number
	function automatic bit num_lead_ch(input logic [7:0] c);
		return digit_ch(c) || c == tts_pkg::CH_PLUS || c == tts_pkg::CH_MINUS ||
			c == tts_pkg::CH_DOT;
	endfunction

	// may continue a number: note E/e continue but never open one
	function automatic bit numeric_ch(input logic [7:0] c);
		return num_lead_ch(c) || c == tts_pkg::CH_E_UP || c == tts_pkg::CH_E_LO;
	endfunction

	// ---------------------------------------------------------------- descriptor prediction

	function automatic void emit_token(input tts_pkg::kind_t k, input logic [31:0] ofs,
			input logic [31:0] len, input logic unt);
		tts_pkg::desc_t d;
		d.kind   = k;
		d.offset = ofs;
		d.length = len;
		d.unterm = unt;
		d.last   = 1'b0;
		pending_tokens.push_back(d);
	endfunction

	// Runs one byte through the shadow tokenizer and queues what it should produce.
	function automatic void predict_tokens(input logic [7:0] ch, input logic eob);
		int             n_prior;
		bit             took;
		bit             goes_on;
		tts_pkg::desc_t tail;
		n_prior = pending_tokens.size();
		took = 1'b0;

		// first let an open token decide whether it swallows this byte
		case (scan_st) inside
		tts_pkg::MODE_IDENT, tts_pkg::MODE_NUM: begin
			goes_on = (scan_st == tts_pkg::MODE_IDENT) ? word_ch(ch) : numeric_ch(ch);
			if (goes_on) begin
				took = 1'b1;
			end else begin
				// closing byte is not part of the token
				if (scan_st == tts_pkg::MODE_IDENT)
					emit_token(tts_pkg::KIND_IDENT, tok_start, cur_pos - tok_start, 1'b0);
				else
					emit_token(tts_pkg::KIND_NUM, tok_start, cur_pos - tok_start, 1'b0);
				scan_st = tts_pkg::MODE_IDLE;
			end
		end
		tts_pkg::MODE_STR: begin
			took = 1'b1;
			if (ch == tts_pkg::CH_BSLASH) begin
				scan_st = tts_pkg::MODE_ESC;
			end else if (ch == tts_pkg::CH_QUOTE) begin
				emit_token(tts_pkg::KIND_STR, tok_start, cur_pos - tok_start + 32'd1, 1'b0);
				scan_st = tts_pkg::MODE_IDLE;
			end
		end
		tts_pkg::MODE_ESC: begin
			// escaped byte is taken whatever it is
			took = 1'b1;
			scan_st = tts_pkg::MODE_STR;
		end
		default: begin
			scan_st = tts_pkg::MODE_IDLE;
		end
		endcase

		// a byte nobody swallowed may open a token or be a token of its own
		if (!took && !blank_ch(ch)) begin
			if (letter_ch(ch) || ch == tts_pkg::CH_UNDERSCORE) begin
				scan_st = tts_pkg::MODE_IDENT;
				tok_start = cur_pos;
			end else if (ch == tts_pkg::CH_QUOTE) begin
				scan_st = tts_pkg::MODE_STR;
				tok_start = cur_pos;
			end else if (num_lead_ch(ch)) begin
				scan_st = tts_pkg::MODE_NUM;
				tok_start = cur_pos;
			end else begin
				emit_token(tts_pkg::KIND_OTHER, cur_pos, 32'd1, 1'b0);
			end
		end

		// end of buffer flushes whatever is open, the marked byte included
		if (eob) begin
			if (scan_st == tts_pkg::MODE_IDENT)
				emit_token(tts_pkg::KIND_IDENT, tok_start, cur_pos - tok_start + 32'd1, 1'b0);
			else if (scan_st == tts_pkg::MODE_NUM)
				emit_token(tts_pkg::KIND_NUM, tok_start, cur_pos - tok_start + 32'd1, 1'b0);
			else if (scan_st == tts_pkg::MODE_STR || scan_st == tts_pkg::MODE_ESC)
				emit_token(tts_pkg::KIND_STR, tok_start, cur_pos - tok_start + 32'd1, 1'b1);
			scan_st = tts_pkg::MODE_IDLE;
			tok_start = '0;
			cur_pos = '0;
		end else begin
			cur_pos = cur_pos + 32'd1;
		end

		// flag the last descriptor this byte gives rise to
		if (pending_tokens.size() > n_prior) begin
			tail = pending_tokens.pop_back();
			tail.last = 1'b1;
			pending_tokens.push_back(tail);
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on descriptor %0d, %s: got 0x%0h, expected 0x%0h",
			$time, tokens_seen, what, got, want);
		mismatches++;
	endtask

	// Both handshakes sampled on the rising edge; inputs are driven on the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_tokens.size() == 0) begin
					report_mismatch("descriptor with nothing expected, offset",
						m_tdata[31:0], 32'd0);
				end else begin
					want_d = pending_tokens.pop_front();
					if (m_tuser[1:0] !== want_d.kind)
						report_mismatch("token_kind", {30'd0, m_tuser[1:0]},
							{30'd0, want_d.kind});
					if (m_tdata[31:0] !== want_d.offset)
						report_mismatch("token_offset", m_tdata[31:0], want_d.offset);
					if (m_tdata[63:32] !== want_d.length)
						report_mismatch("token_length", m_tdata[63:32], want_d.length);
					if (m_tuser[2] !== want_d.unterm)
						report_mismatch("unterminated", {31'd0, m_tuser[2]},
							{31'd0, want_d.unterm});
					if (m_tlast !== want_d.last)
						report_mismatch("final_of_run", {31'd0, m_tlast},
							{31'd0, want_d.last});
				end
				tokens_seen++;
			end
			if (s_tvalid && s_tready) begin
				predict_tokens(s_tdata, s_tlast);
				bytes_taken++;
				if (s_tlast)
					buffers_taken++;
			end
		end
	end

	// Watchdog: a long spell with no transaction on either side means a hang.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d descriptors outstanding",
				quiet_cycles, pending_tokens.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receive side back-pressure.
	always @(negedge clk) begin
		m_tready <= rx_idle ? ($urandom_range(99) >= 29) : 1'b1;
	end

	// ---------------------------------------------------------------- stimulus helpers

	// Called at a falling edge; returns at the falling edge after acceptance with
	// tvalid still high, so the caller's next drive is the only one in that step.
	task automatic send_byte(input logic [7:0] b, input logic eob);
		while (tx_idle && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sends text_buf, marking the last byte as end of buffer when asked.
	task automatic send_buffer(input bit close);
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], close && (i == text_buf.size() - 1));
	endtask

	task automatic send_text(input string s, input bit close);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_buffer(close);
	endtask

	// Holds the sender off until every predicted descriptor has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_tokens.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_from(input string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	// Appends one token-shaped fragment, or a bit of noise, to text_buf.
	task automatic add_fragment();
		int n;
		case ($urandom_range(9))
		0, 1, 2: begin
			text_buf.push_back(pick_from(
				"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
			n = $urandom_range(8);
			repeat (n)
				text_buf.push_back(pick_from(
					"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789"));
		end
		3, 4: begin
			text_buf.push_back(pick_from("+-.0123456789"));
			n = $urandom_range(6);
			repeat (n)
				text_buf.push_back(pick_from("0123456789+-.Ee"));
		end
		5: begin
			text_buf.push_back(tts_pkg::CH_QUOTE);
			n = $urandom_range(6);
			repeat (n) begin
				if ($urandom_range(4) == 0) begin
					// escape followed by any byte, a quote included
					text_buf.push_back(tts_pkg::CH_BSLASH);
					text_buf.push_back(8'($urandom_range(255)));
				end else begin
					text_buf.push_back(8'($urandom_range(32, 126)));
				end
			end
			if ($urandom_range(7) != 0)
				text_buf.push_back(tts_pkg::CH_QUOTE);
		end
		6, 7: begin
			n = $urandom_range(1, 3);
			repeat (n)
				text_buf.push_back(pick_from(" \t\r\n"));
		end
		8: text_buf.push_back(pick_from("();,*/=<>{}[]#!?&|~^%@$"));
		default: text_buf.push_back(8'($urandom_range(255)));
		endcase
	endtask

	// Random buffer of exactly len bytes; cutting to length can leave tokens open at the end.
	task automatic fill_random_buffer(input int len);
		text_buf.delete();
		while (text_buf.size() < len)
			add_fragment();
		while (text_buf.size() > len)
			void'(text_buf.pop_back());
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_cases();
		// identifier closed by a sign that opens a number, which the end of buffer flushes
		send_text("ab_9+", 1'b1);
		// closed string, then a number with E ended by a one-byte token, that byte giving two descriptors
		send_text("\"q\"-1.E;", 1'b1);
		// top and bottom byte values as one-byte tokens
		text_buf.delete();
		text_buf.push_back(8'hFF);
		text_buf.push_back(8'h00);
		send_buffer(1'b1);
		// string cut off right after a backslash
		send_text("\"x\\", 1'b1);
		// identifier closed by a quote, string left open at end of buffer
		send_text("z\"", 1'b1);
		// separators only, buffer ends on one
		send_text(" \t\r\n", 1'b1);
	endtask

	task automatic test_drain_pause();
		// stop halfway through a buffer with closed tokens, drain, then resume it
		send_text("abc 12 (", 1'b0);
		wait_drained();
		send_text("x7 -", 1'b1);
	endtask

	task automatic test_back_to_back(input int n_bytes);
		int sent;
		sent = 0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (sent < n_bytes) begin
			fill_random_buffer($urandom_range(1, 40));
			send_buffer(1'b1);
			sent += text_buf.size();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_random_text(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(7) == 0)
				fill_random_buffer($urandom_range(1, 3));
			else
				fill_random_buffer($urandom_range(1, 40));
			send_buffer(1'b1);
			sent += text_buf.size();
			if ($urandom_range(24) == 0)
				wait_drained();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_drain_pause();
		test_back_to_back(200);
		test_random_text(780);

		// let the block empty, then wait out the settle period for anything stray
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (pending_tokens.size() != 0)
			report_mismatch("descriptors still outstanding at end",
				32'(pending_tokens.size()), 32'd0);

		$display("Run covered %0d bytes in %0d buffers and compared %0d descriptors,",
			bytes_taken, buffers_taken, tokens_seen);
		$display("over directed, drain-pause, back-to-back and random text phases.");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
